// ===== hdl/signed_int_to_radix_text_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the signed integer to radix text block
// Concurrent property wrappers with clock, active-low reset and a message.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_RADIX_TEXT_MACROS_SVH
`define SIGNED_INT_TO_RADIX_TEXT_MACROS_SVH

// same-cycle implication
`define SIRT_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SIRT_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sirt_pkg.sv =====
// ----------------------------------------------------------------------------
// sirt_pkg
// Types, constants and the symbol lookup shared by the radix text block.
// ----------------------------------------------------------------------------
package sirt_pkg;

  localparam int VALUE_W    = 32;
  localparam int CHAR_W     = 8;
  localparam int RADIX_W    = 5;
  localparam int SYM_W      = 64;
  localparam int SYM_IDX_W  = 4;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 64;
  localparam int DIV_BITS   = 8;
  localparam int CHUNKS     = VALUE_W / DIV_BITS;
  localparam int STEP_W     = $clog2(CHUNKS);
  localparam int MAX_DIGITS = VALUE_W;
  localparam int DIDX_W     = $clog2(MAX_DIGITS);
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CHUNKS - 1);

  localparam logic [1:0] REG_RADIX    = 2'd0;
  localparam logic [1:0] REG_SYMS_LOW = 2'd1;
  localparam logic [1:0] REG_SYMS_HI  = 2'd2;

  localparam logic [RADIX_W-1:0] RADIX_RST    = 5'd10;
  localparam logic [SYM_W-1:0]   SYMS_LOW_RST = 64'h3736353433323130;
  localparam logic [SYM_W-1:0]   SYMS_HI_RST  = 64'h0000000000003938;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_EMIT
  } state_e;

  function automatic logic [CHAR_W-1:0] symbol_at(input logic [SYM_W-1:0] lo,
                                                  input logic [SYM_W-1:0] hi,
                                                  input logic [SYM_IDX_W-1:0] idx);
    logic [SYM_W-1:0] word;
    word = idx[SYM_IDX_W-1] ? hi : lo;
    return word[idx[SYM_IDX_W-2:0] * CHAR_W +: CHAR_W];
  endfunction

endpackage

// ===== hdl/sirt_alpha_chk.sv =====
// ----------------------------------------------------------------------------
// sirt_alpha_chk
// Flags whether the configured radix and symbol alphabet can be used.
// ----------------------------------------------------------------------------
module sirt_alpha_chk #(
  parameter int MAX_RADIX = 16
) (
  input  logic [sirt_pkg::RADIX_W-1:0] radix_i,
  input  logic [sirt_pkg::SYM_W-1:0]   syms_low_i,
  input  logic [sirt_pkg::SYM_W-1:0]   syms_high_i,
  output logic                         ok_o
);

  localparam logic [sirt_pkg::RADIX_W-1:0] MaxRadixC = sirt_pkg::RADIX_W'(MAX_RADIX);
  localparam int NSYM = 2 ** sirt_pkg::SYM_IDX_W;

  logic [sirt_pkg::CHAR_W-1:0] sym [NSYM];

  always_comb begin
    for (int i = 0; i < NSYM; i++) begin
      sym[i] = sirt_pkg::symbol_at(syms_low_i, syms_high_i, sirt_pkg::SYM_IDX_W'(i));
    end
  end

  always_comb begin
    ok_o = (radix_i >= 5'd2) && (radix_i <= MaxRadixC);
    for (int i = 0; i < NSYM; i++) begin
      if (sirt_pkg::RADIX_W'(i) < radix_i) begin
        if (sym[i] == sirt_pkg::CHAR_PLUS || sym[i] == sirt_pkg::CHAR_MINUS ||
            sym[i] == sirt_pkg::CHAR_NUL) begin
          ok_o = 1'b0;
        end
        for (int j = i + 1; j < NSYM; j++) begin
          if (sirt_pkg::RADIX_W'(j) < radix_i && sym[j] == sym[i]) begin
            ok_o = 1'b0;
          end
        end
      end
    end
  end

endmodule

// ===== hdl/sirt_divstep.sv =====
// ----------------------------------------------------------------------------
// sirt_divstep
// Restoring division slice: shifts a chunk of dividend bits through the
// remainder, producing the matching quotient bits.
// ----------------------------------------------------------------------------
module sirt_divstep #(
  parameter int DIGIT_W = 4
) (
  input  logic [DIGIT_W-1:0]            rem_i,
  input  logic [sirt_pkg::DIV_BITS-1:0] bits_i,
  input  logic [sirt_pkg::RADIX_W-1:0]  base_i,
  output logic [DIGIT_W-1:0]            rem_o,
  output logic [sirt_pkg::DIV_BITS-1:0] quo_o
);

  localparam int CMP_W = (DIGIT_W + 1 > sirt_pkg::RADIX_W) ? DIGIT_W + 1 : sirt_pkg::RADIX_W;

  logic [DIGIT_W-1:0] r;
  logic [DIGIT_W:0]   t;
  logic [CMP_W-1:0]   te;
  logic [CMP_W-1:0]   be;
  logic [CMP_W-1:0]   diff;

  always_comb begin
    r     = rem_i;
    quo_o = '0;
    be    = '0;
    be[sirt_pkg::RADIX_W-1:0] = base_i;
    for (int k = sirt_pkg::DIV_BITS - 1; k >= 0; k--) begin
      t  = {r, bits_i[k]};
      te = '0;
      te[DIGIT_W:0] = t;
      diff = te - be;
      if (te >= be) begin
        r        = diff[DIGIT_W-1:0];
        quo_o[k] = 1'b1;
      end else begin
        r = t[DIGIT_W-1:0];
      end
    end
    rem_o = r;
  end

endmodule

// ===== hdl/signed_int_to_radix_text.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_radix_text
// Converts a signed 32-bit value to text in a configurable radix.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries the value (tdata[31:0]); m_axis returns one character per
//   transfer (tdata[7:0]), most significant digit first, a leading '-' for
//   negatives, tlast on the final character. The APB port holds radix (0x00),
//   symbols 0..7 (0x08) and symbols 8..15 (0x10); write them only while idle.
//   An item is taken only while the block is idle. With an invalid alphabet
//   the item is dropped and the block stays ready.
//   The digits come from one shared remainder unit that retires 8 dividend
//   bits per cycle; each digit is the remainder of a full pass over the value,
//   and all digits are found before the first character. Characters then leave
//   one per cycle while the receiver is ready, a '-' first for negatives, and
//   the block afterwards returns to idle to take the next value.
//   A stalled receiver holds the current character and tlast in place.
//   Reset returns to idle with radix 10 and the alphabet "0123456789".
// ----------------------------------------------------------------------------
module signed_int_to_radix_text #(
  parameter int MAX_RADIX = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // fields: value[31:0]
  input  logic [sirt_pkg::VALUE_W-1:0]  s_axis_tdata,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // fields: character[7:0]
  output logic [sirt_pkg::CHAR_W-1:0]   m_axis_tdata,
  output logic                          m_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sirt_pkg::ADDR_W-1:0]   paddr,
  input  logic [sirt_pkg::DATA_W-1:0]   pwdata,
  output logic [sirt_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int DIGIT_W = $clog2(MAX_RADIX);

  sirt_pkg::state_e                 state_q, state_d;
  logic [sirt_pkg::RADIX_W-1:0]     radix_q;
  logic [sirt_pkg::SYM_W-1:0]       syms_low_q;
  logic [sirt_pkg::SYM_W-1:0]       syms_high_q;
  logic [sirt_pkg::VALUE_W-1:0]     work_q, work_d;
  logic [DIGIT_W-1:0]               rem_q, rem_d;
  logic [sirt_pkg::STEP_W-1:0]      step_q, step_d;
  logic [sirt_pkg::CNT_W-1:0]       cnt_q, cnt_d;
  logic                             neg_q, neg_d;
  logic [DIGIT_W-1:0]               digits_q [sirt_pkg::MAX_DIGITS];

  logic                             alpha_ok;
  logic [DIGIT_W-1:0]               rem_next;
  logic [sirt_pkg::DIV_BITS-1:0]    quo_bits;
  logic                             in_xfer;
  logic                             out_xfer;
  logic                             cfg_wr;
  logic                             digit_done;
  logic                             div_last;
  logic [sirt_pkg::CNT_W-1:0]       cnt_m1;
  logic [sirt_pkg::DIDX_W-1:0]      rd_idx;
  logic [sirt_pkg::DIDX_W-1:0]      wr_idx;
  logic [sirt_pkg::SYM_IDX_W-1:0]   sym_idx;

  sirt_alpha_chk #(
    .MAX_RADIX (MAX_RADIX)
  ) u_alpha_chk (
    .radix_i     (radix_q),
    .syms_low_i  (syms_low_q),
    .syms_high_i (syms_high_q),
    .ok_o        (alpha_ok)
  );

  sirt_divstep #(
    .DIGIT_W (DIGIT_W)
  ) u_divstep (
    .rem_i  (rem_q),
    .bits_i (work_q[sirt_pkg::VALUE_W-1 -: sirt_pkg::DIV_BITS]),
    .base_i (radix_q),
    .rem_o  (rem_next),
    .quo_o  (quo_bits)
  );

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q     <= sirt_pkg::RADIX_RST;
      syms_low_q  <= sirt_pkg::SYMS_LOW_RST;
      syms_high_q <= sirt_pkg::SYMS_HI_RST;
    end else if (cfg_wr) begin
      unique case (paddr[4:3])
        sirt_pkg::REG_RADIX:    radix_q     <= pwdata[sirt_pkg::RADIX_W-1:0];
        sirt_pkg::REG_SYMS_LOW: syms_low_q  <= pwdata;
        sirt_pkg::REG_SYMS_HI:  syms_high_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      sirt_pkg::REG_RADIX: begin
        prdata = '0;
        prdata[sirt_pkg::RADIX_W-1:0] = radix_q;
      end
      sirt_pkg::REG_SYMS_LOW: prdata = syms_low_q;
      sirt_pkg::REG_SYMS_HI:  prdata = syms_high_q;
      default:                prdata = '0;
    endcase
  end

  // handshakes and sequencer status
  assign in_xfer    = s_axis_tvalid && s_axis_tready;
  assign out_xfer   = m_axis_tvalid && m_axis_tready;
  assign div_last   = (step_q == sirt_pkg::LAST_STEP);
  assign digit_done = (state_q == sirt_pkg::ST_DIV) && div_last;
  assign cnt_m1     = cnt_q - 1'b1;
  assign rd_idx     = cnt_m1[sirt_pkg::DIDX_W-1:0];
  assign wr_idx     = cnt_q[sirt_pkg::DIDX_W-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sirt_pkg::ST_IDLE: begin
        if (in_xfer && alpha_ok) state_d = sirt_pkg::ST_DIV;
      end
      sirt_pkg::ST_DIV: begin
        if (div_last && ({work_q[sirt_pkg::VALUE_W-sirt_pkg::DIV_BITS-1:0], quo_bits} == '0 ||
                         cnt_q == sirt_pkg::CNT_W'(sirt_pkg::MAX_DIGITS - 1))) begin
          state_d = neg_q ? sirt_pkg::ST_SIGN : sirt_pkg::ST_EMIT;
        end
      end
      sirt_pkg::ST_SIGN: begin
        if (out_xfer) state_d = sirt_pkg::ST_EMIT;
      end
      sirt_pkg::ST_EMIT: begin
        if (out_xfer && cnt_q == sirt_pkg::CNT_W'(1)) state_d = sirt_pkg::ST_IDLE;
      end
      default: state_d = sirt_pkg::ST_IDLE;
    endcase
  end

  // datapath next values
  always_comb begin
    work_d = work_q;
    rem_d  = rem_q;
    step_d = step_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    unique case (state_q)
      sirt_pkg::ST_IDLE: begin
        if (in_xfer) begin
          neg_d  = s_axis_tdata[sirt_pkg::VALUE_W-1];
          work_d = s_axis_tdata[sirt_pkg::VALUE_W-1] ? (~s_axis_tdata + 1'b1) : s_axis_tdata;
          rem_d  = '0;
          step_d = '0;
          cnt_d  = '0;
        end
      end
      sirt_pkg::ST_DIV: begin
        work_d = {work_q[sirt_pkg::VALUE_W-sirt_pkg::DIV_BITS-1:0], quo_bits};
        step_d = step_q + 1'b1;
        if (div_last) begin
          rem_d = '0;
          cnt_d = cnt_q + 1'b1;
        end else begin
          rem_d = rem_next;
        end
      end
      sirt_pkg::ST_EMIT: begin
        if (out_xfer) cnt_d = cnt_m1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sirt_pkg::ST_IDLE;
      step_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
    neg_q  <= neg_d;
  end

  // digit stack, least significant digit pushed first
  always_ff @(posedge clk_i) begin
    if (digit_done) digits_q[wr_idx] <= rem_next;
  end

  always_comb begin
    sym_idx = '0;
    sym_idx[DIGIT_W-1:0] = digits_q[rd_idx];
  end

  // outputs
  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    m_axis_tdata  = sirt_pkg::symbol_at(syms_low_q, syms_high_q, sym_idx);
    m_axis_tlast  = 1'b0;
    unique case (state_q)
      sirt_pkg::ST_IDLE: s_axis_tready = 1'b1;
      sirt_pkg::ST_DIV:  ;
      sirt_pkg::ST_SIGN: begin
        m_axis_tvalid = 1'b1;
        m_axis_tdata  = sirt_pkg::CHAR_MINUS;
      end
      sirt_pkg::ST_EMIT: begin
        m_axis_tvalid = 1'b1;
        m_axis_tlast  = (cnt_q == sirt_pkg::CNT_W'(1));
      end
      default: ;
    endcase
  end

endmodule

// ===== hdl/sirt_checker.sv =====
// ----------------------------------------------------------------------------
// sirt_checker
// Port-level properties of the radix text block, bound to its top level.
// ----------------------------------------------------------------------------
`include "signed_int_to_radix_text_macros.svh"

module sirt_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tlast,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready
);

  logic in_xfer;
  logic last_xfer;
  logic stall;

  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign last_xfer = m_axis_tvalid && m_axis_tready && m_axis_tlast;
  assign stall     = m_axis_tvalid && !m_axis_tready;

  `SIRT_ASSERT_IMP(a_ready_excl_valid, clk_i, rst_ni, s_axis_tready, !m_axis_tvalid, "ready while busy")
  `SIRT_ASSERT_NXT(a_accept_no_char, clk_i, rst_ni, in_xfer, !m_axis_tvalid, "early character")
  `SIRT_ASSERT_NXT(a_last_ends_text, clk_i, rst_ni, last_xfer, !m_axis_tvalid, "character after last")
  `SIRT_ASSERT_NXT(a_stall_hold, clk_i, rst_ni, stall, m_axis_tvalid && $stable(m_axis_tlast), "stall lost")

endmodule

bind signed_int_to_radix_text sirt_checker u_sirt_checker (.*);
